@@ design/assert_macros.svh @@
// Assertion helpers used by ffsa_back; both sample on clk_i and hold off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CHK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define ASSERT_NEVER(lbl, cond, msg) \
  `ASSERT_CHK(lbl, !(cond), msg)

`endif

@@ design/ffsa_pkg.sv @@
`default_nettype none

package ffsa_pkg;

  localparam int unsigned POOL_DEPTH = 64;

  localparam int unsigned CAP_W    = 7;
  localparam int unsigned SLOT_W   = 6;
  localparam int unsigned LIVE_W   = 7;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_RANGE    = 2'd2,
    ST_NOT_LIVE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CMD_ALLOC,
    CMD_RELEASE,
    CMD_RANGE
  } cmd_kind_e;

  typedef struct packed {
    status_e              status;
    logic [SLOT_W-1:0]    granted_slot;
    logic [LIVE_W-1:0]    live_count;
  } result_t;

endpackage

`default_nettype wire

@@ design/ffsa_queue.sv @@
`default_nettype none

module ffsa_queue #(
  parameter int unsigned Width = 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             wr_en_i,
  input  wire logic [Width-1:0] wr_data_i,
  output logic                  full_o,
  input  wire logic             rd_en_i,
  output logic [Width-1:0]      rd_data_o,
  output logic                  empty_o
);

  logic [Width-1:0] mem_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       cnt_q;
  logic             do_push, do_pop;

  assign full_o    = (cnt_q == 2'd2);
  assign empty_o   = (cnt_q == 2'd0);
  assign do_push   = wr_en_i && !full_o;
  assign do_pop    = rd_en_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_pop) rd_ptr_q <= !rd_ptr_q;
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= wr_data_i;
  end

endmodule

`default_nettype wire

@@ design/ffsa_front.sv @@
`default_nettype none

module ffsa_front #(
  parameter int unsigned PoolDepth = ffsa_pkg::POOL_DEPTH
) (
  input  wire logic                           push_i,
  output logic                                full_o,
  input  wire logic                           operation_i,
  input  wire logic [ffsa_pkg::SLOT_W-1:0]    release_slot_i,
  input  wire logic [$clog2(PoolDepth+1)-1:0] cap_eff_i,
  input  wire logic                           cmdq_full_i,
  input  wire logic                           clearing_i,
  output logic                                cmdq_push_o,
  output ffsa_pkg::cmd_kind_e                 kind_o,
  output logic [$clog2(PoolDepth)-1:0]        slot_o
);

  localparam int unsigned SlotW = $clog2(PoolDepth);
  localparam int unsigned CntW  = $clog2(PoolDepth + 1);
  localparam int unsigned CmpW  = (CntW > ffsa_pkg::SLOT_W) ? CntW : ffsa_pkg::SLOT_W;

  logic out_of_range;

  // hold off new words while the command queue is full or the back end sweeps the in-use map
  assign full_o      = cmdq_full_i || clearing_i;
  assign cmdq_push_o = push_i && !full_o;

  assign out_of_range = CmpW'(release_slot_i) >= CmpW'(cap_eff_i);
  // in-range slots are below the pool depth, so the narrowing is lossless
  assign slot_o       = SlotW'(release_slot_i);

  always_comb begin
    kind_o = ffsa_pkg::CMD_ALLOC;
    if (operation_i == ffsa_pkg::OP_RELEASE) begin
      kind_o = out_of_range ? ffsa_pkg::CMD_RANGE : ffsa_pkg::CMD_RELEASE;
    end
  end

endmodule

`default_nettype wire

@@ design/ffsa_back.sv @@
`default_nettype none

`include "assert_macros.svh"

module ffsa_back #(
  parameter int unsigned PoolDepth = ffsa_pkg::POOL_DEPTH
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic [$clog2(PoolDepth+1)-1:0] cap_eff_i,
  input  wire logic                           cmd_empty_i,
  input  wire ffsa_pkg::cmd_kind_e            cmd_kind_i,
  input  wire logic [$clog2(PoolDepth)-1:0]   cmd_slot_i,
  output logic                                cmd_pop_o,
  input  wire logic                           res_full_i,
  output logic                                res_push_o,
  output ffsa_pkg::result_t                   res_o,
  output logic                                clearing_o
);

  localparam int unsigned SlotW = $clog2(PoolDepth);
  localparam int unsigned CntW  = $clog2(PoolDepth + 1);
  localparam logic [SlotW-1:0] LastIdx = SlotW'(PoolDepth - 1);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_e;

  state_e              state_q;
  logic [SlotW-1:0]    clr_addr_q;
  logic [SlotW-1:0]    head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0]     fill_q, fill_d, live_q, live_d;
  ffsa_pkg::cmd_kind_e kind_q;
  logic [SlotW-1:0]    slot_q;

  logic                map_mem [PoolDepth];
  logic [SlotW-1:0]    fifo_mem [PoolDepth];
  logic                map_rd_q;
  logic [SlotW-1:0]    fifo_rd_q;

  logic                map_we, map_wd, fifo_we;
  logic [SlotW-1:0]    map_wa, grant_idx;
  ffsa_pkg::status_e   status;
  logic                exec_go;

  function automatic logic [SlotW-1:0] ring_next(logic [SlotW-1:0] p);
    return (p == LastIdx) ? '0 : p + SlotW'(1);
  endfunction

  assign clearing_o = (state_q == S_CLEAR);
  assign cmd_pop_o  = (state_q == S_IDLE) && !cmd_empty_i;
  assign exec_go    = (state_q == S_EXEC) && !res_full_i;
  assign res_push_o = exec_go;

  always_comb begin
    status    = ffsa_pkg::ST_OK;
    grant_idx = '0;
    live_d    = live_q;
    fill_d    = fill_q;
    head_d    = head_q;
    tail_d    = tail_q;
    map_we    = 1'b0;
    map_wa    = slot_q;
    map_wd    = 1'b0;
    fifo_we   = 1'b0;
    if (state_q == S_CLEAR) begin
      map_we = 1'b1;
      map_wa = clr_addr_q;
    end else if (exec_go) begin
      case (kind_q)
        ffsa_pkg::CMD_ALLOC: begin
          if (live_q >= cap_eff_i) begin
            status = ffsa_pkg::ST_FULL;
          end else begin
            if (fill_q != '0) begin
              grant_idx = fifo_rd_q;
              head_d    = ring_next(head_q);
              fill_d    = fill_q - CntW'(1);
            end else begin
              // fresh slot: live count is below the capacity, so it fits
              grant_idx = live_q[SlotW-1:0];
            end
            map_we = 1'b1;
            map_wa = grant_idx;
            map_wd = 1'b1;
            live_d = live_q + CntW'(1);
          end
        end
        ffsa_pkg::CMD_RELEASE: begin
          if (!map_rd_q) begin
            status = ffsa_pkg::ST_NOT_LIVE;
          end else begin
            map_we = 1'b1;
            if (fill_q < CntW'(PoolDepth)) begin
              fifo_we = 1'b1;
              tail_d  = ring_next(tail_q);
              fill_d  = fill_q + CntW'(1);
            end
            if (live_q != '0) live_d = live_q - CntW'(1);
          end
        end
        default: status = ffsa_pkg::ST_RANGE;
      endcase
    end
  end

  assign res_o.status       = status;
  assign res_o.granted_slot = ffsa_pkg::SLOT_W'(grant_idx);
  assign res_o.live_count   = ffsa_pkg::LIVE_W'(live_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      clr_addr_q <= '0;
      head_q     <= '0;
      tail_q     <= '0;
      fill_q     <= '0;
      live_q     <= '0;
      kind_q     <= ffsa_pkg::CMD_ALLOC;
      slot_q     <= '0;
    end else begin
      case (state_q)
        S_CLEAR: begin
          clr_addr_q <= clr_addr_q + SlotW'(1);
          if (clr_addr_q == LastIdx) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (cmd_pop_o) begin
            kind_q  <= cmd_kind_i;
            slot_q  <= cmd_slot_i;
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (exec_go) begin
            head_q  <= head_d;
            tail_q  <= tail_d;
            fill_q  <= fill_d;
            live_q  <= live_d;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // read both stores as the word leaves the queue; hold data while stalled
  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      map_rd_q  <= map_mem[cmd_slot_i];
      fifo_rd_q <= fifo_mem[head_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (map_we) map_mem[map_wa] <= map_wd;
  end

  always_ff @(posedge clk_i) begin
    if (fifo_we) fifo_mem[tail_q] <= slot_q;
  end

  `ASSERT_CHK(pop_to_exec_a, cmd_pop_o |=> (state_q == S_EXEC), "popped word not executed")
  `ASSERT_NEVER(ring_ptr_a, (fill_q == '0 || fill_q == CntW'(PoolDepth)) && head_q != tail_q, "free list pointers disagree with fill")
  `ASSERT_NEVER(count_bound_a, fill_q > CntW'(PoolDepth) || live_q > CntW'(PoolDepth), "counter beyond pool depth")

endmodule

`default_nettype wire

@@ design/fifo_free_list_slot_allocator_unit.sv @@
// Slot allocator with a FIFO free list. Requests enter through push/full and results leave
// through empty/pop, one result per request, in order. In the back end, S_IDLE registers the
// read of the in-use map and free list as the request is popped, then S_EXEC does the update
// and result write once the result queue has room; a two-entry queue on each side lets the
// sides run on their own. After reset the in-use map is swept clear, one slot a cycle, while
// full stays high. Write capacity only while no request is in flight.
`default_nettype none

module fifo_free_list_slot_allocator_unit #(
  parameter int unsigned PoolDepth = ffsa_pkg::POOL_DEPTH
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [ffsa_pkg::CAP_W-1:0]   cfg_wdata_i,
  input  wire logic                         push,
  output logic                              full,
  input  wire logic                         operation_i,
  input  wire logic [ffsa_pkg::SLOT_W-1:0]  release_slot_i,
  output logic                              empty,
  input  wire logic                         pop,
  output logic [1:0]                        status_o,
  output logic [ffsa_pkg::SLOT_W-1:0]       granted_slot_o,
  output logic [ffsa_pkg::LIVE_W-1:0]       live_count_o
);

  localparam int unsigned SlotW = $clog2(PoolDepth);
  localparam int unsigned CntW  = $clog2(PoolDepth + 1);
  localparam int unsigned CmpW  = (CntW > ffsa_pkg::CAP_W) ? CntW : ffsa_pkg::CAP_W;
  localparam int unsigned KindW = $bits(ffsa_pkg::cmd_kind_e);
  localparam int unsigned CmdW  = KindW + SlotW;
  localparam int unsigned ResW  = $bits(ffsa_pkg::result_t);

  logic [ffsa_pkg::CAP_W-1:0] cap_q;
  logic [CntW-1:0]            cap_eff;

  ffsa_pkg::cmd_kind_e  fe_kind, cmd_kind;
  logic [SlotW-1:0]     fe_slot, cmd_slot;
  logic                 cmdq_push, cmdq_full, cmdq_empty, cmd_pop, clearing;
  logic [CmdW-1:0]      cmdq_rdata;

  ffsa_pkg::result_t    be_res, out_res;
  logic                 res_push, res_full;
  logic [ResW-1:0]      resq_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= ffsa_pkg::CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  // clamp to the built depth
  assign cap_eff = (CmpW'(cap_q) < CmpW'(PoolDepth)) ? CntW'(cap_q) : CntW'(PoolDepth);

  ffsa_front #(
    .PoolDepth(PoolDepth)
  ) u_front (
    .push_i        (push),
    .full_o        (full),
    .operation_i   (operation_i),
    .release_slot_i(release_slot_i),
    .cap_eff_i     (cap_eff),
    .cmdq_full_i   (cmdq_full),
    .clearing_i    (clearing),
    .cmdq_push_o   (cmdq_push),
    .kind_o        (fe_kind),
    .slot_o        (fe_slot)
  );

  ffsa_queue #(
    .Width(CmdW)
  ) u_cmd_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (cmdq_push),
    .wr_data_i({fe_kind, fe_slot}),
    .full_o   (cmdq_full),
    .rd_en_i  (cmd_pop),
    .rd_data_o(cmdq_rdata),
    .empty_o  (cmdq_empty)
  );

  assign cmd_kind = ffsa_pkg::cmd_kind_e'(cmdq_rdata[SlotW +: KindW]);
  assign cmd_slot = cmdq_rdata[SlotW-1:0];

  ffsa_back #(
    .PoolDepth(PoolDepth)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cap_eff_i  (cap_eff),
    .cmd_empty_i(cmdq_empty),
    .cmd_kind_i (cmd_kind),
    .cmd_slot_i (cmd_slot),
    .cmd_pop_o  (cmd_pop),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_o      (be_res),
    .clearing_o (clearing)
  );

  ffsa_queue #(
    .Width(ResW)
  ) u_res_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (res_push),
    .wr_data_i(be_res),
    .full_o   (res_full),
    .rd_en_i  (pop),
    .rd_data_o(resq_rdata),
    .empty_o  (empty)
  );

  assign out_res        = resq_rdata;
  assign status_o       = out_res.status;
  assign granted_slot_o = out_res.granted_slot;
  assign live_count_o   = out_res.live_count;

endmodule

`default_nettype wire

@@ dv/fifo_free_list_slot_allocator_unit_tb.sv @@
`timescale 1ns / 100ps

module fifo_free_list_slot_allocator_unit_tb;

  localparam int unsigned RANDOM_ITEMS  = 1900;
  localparam int unsigned QUIET_TAIL    = 250;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned DRAIN_CYCLES  = 20;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned PRINT_LIMIT   = 40;

  typedef enum logic {
    ROW_REQUEST,
    ROW_CAPACITY
  } row_kind_e;

  // arg holds the slot for a request row and the new capacity for a capacity row
  typedef struct packed {
    row_kind_e                   kind;
    logic                        op;
    logic [ffsa_pkg::CAP_W-1:0]  arg;
    logic                        typed;
    ffsa_pkg::status_e           status;
    logic [ffsa_pkg::SLOT_W-1:0] granted_slot;
    logic [ffsa_pkg::LIVE_W-1:0] live_count;
  } stim_row_t;

  localparam int unsigned NUM_ROWS = 23;

  stim_row_t directed_rows [NUM_ROWS] = '{
    '{ROW_REQUEST,  ffsa_pkg::OP_ALLOC,   7'd0,   1'b1, ffsa_pkg::ST_OK,       6'd0, 7'd1},
    '{ROW_REQUEST,  ffsa_pkg::OP_ALLOC,   7'd0,   1'b1, ffsa_pkg::ST_OK,       6'd1, 7'd2},
    '{ROW_REQUEST,  ffsa_pkg::OP_RELEASE, 7'd1,   1'b1, ffsa_pkg::ST_OK,       6'd0, 7'd1},
    '{ROW_REQUEST,  ffsa_pkg::OP_RELEASE, 7'd1,   1'b1, ffsa_pkg::ST_NOT_LIVE, 6'd0, 7'd1},
    '{ROW_REQUEST,  ffsa_pkg::OP_RELEASE, 7'd63,  1'b1, ffsa_pkg::ST_NOT_LIVE, 6'd0, 7'd1},
    '{ROW_REQUEST,  ffsa_pkg::OP_ALLOC,   7'd0,   1'b0, ffsa_pkg::ST_OK,       6'd0, 7'd0},
    '{ROW_REQUEST,  ffsa_pkg::OP_ALLOC,   7'd0,   1'b0, ffsa_pkg::ST_OK,       6'd0, 7'd0},
    '{ROW_REQUEST,  ffsa_pkg::OP_RELEASE, 7'd0,   1'b0, ffsa_pkg::ST_OK,       6'd0, 7'd0},
    '{ROW_REQUEST,  ffsa_pkg::OP_RELEASE, 7'd2,   1'b0, ffsa_pkg::ST_OK,       6'd0, 7'd0},
    '{ROW_REQUEST,  ffsa_pkg::OP_ALLOC,   7'd0,   1'b0, ffsa_pkg::ST_OK,       6'd0, 7'd0},
    '{ROW_CAPACITY, ffsa_pkg::OP_ALLOC,   7'd0,   1'b0, ffsa_pkg::ST_OK,       6'd0, 7'd0},
    '{ROW_REQUEST,  ffsa_pkg::OP_ALLOC,   7'd0,   1'b1, ffsa_pkg::ST_FULL,     6'd0, 7'd2},
    '{ROW_REQUEST,  ffsa_pkg::OP_RELEASE, 7'd0,   1'b1, ffsa_pkg::ST_RANGE,    6'd0, 7'd2},
    '{ROW_CAPACITY, ffsa_pkg::OP_ALLOC,   7'd1,   1'b0, ffsa_pkg::ST_OK,       6'd0, 7'd0},
    '{ROW_REQUEST,  ffsa_pkg::OP_ALLOC,   7'd0,   1'b1, ffsa_pkg::ST_FULL,     6'd0, 7'd2},
    '{ROW_REQUEST,  ffsa_pkg::OP_RELEASE, 7'd1,   1'b1, ffsa_pkg::ST_RANGE,    6'd0, 7'd2},
    '{ROW_REQUEST,  ffsa_pkg::OP_RELEASE, 7'd0,   1'b0, ffsa_pkg::ST_OK,       6'd0, 7'd0},
    '{ROW_REQUEST,  ffsa_pkg::OP_ALLOC,   7'd0,   1'b1, ffsa_pkg::ST_FULL,     6'd0, 7'd1},
    '{ROW_CAPACITY, ffsa_pkg::OP_ALLOC,   7'd127, 1'b0, ffsa_pkg::ST_OK,       6'd0, 7'd0},
    '{ROW_REQUEST,  ffsa_pkg::OP_RELEASE, 7'd63,  1'b1, ffsa_pkg::ST_NOT_LIVE, 6'd0, 7'd1},
    '{ROW_REQUEST,  ffsa_pkg::OP_ALLOC,   7'd0,   1'b0, ffsa_pkg::ST_OK,       6'd0, 7'd0},
    '{ROW_CAPACITY, ffsa_pkg::OP_ALLOC,   7'd64,  1'b0, ffsa_pkg::ST_OK,       6'd0, 7'd0},
    '{ROW_REQUEST,  ffsa_pkg::OP_RELEASE, 7'd1,   1'b0, ffsa_pkg::ST_OK,       6'd0, 7'd0}
  };

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        cfg_we_i = 1'b0;
  logic [ffsa_pkg::CAP_W-1:0]  cfg_wdata_i = '0;
  logic                        push = 1'b0;
  logic                        full;
  logic                        operation_i = ffsa_pkg::OP_ALLOC;
  logic [ffsa_pkg::SLOT_W-1:0] release_slot_i = '0;
  logic                        empty;
  logic                        pop = 1'b0;
  logic [1:0]                  status_o;
  logic [ffsa_pkg::SLOT_W-1:0] granted_slot_o;
  logic [ffsa_pkg::LIVE_W-1:0] live_count_o;

  // allocator mirror
  logic [ffsa_pkg::CAP_W-1:0]      capacity_q = ffsa_pkg::CAP_RESET;
  logic [ffsa_pkg::SLOT_W-1:0]     free_ring [ffsa_pkg::POOL_DEPTH];
  logic [ffsa_pkg::SLOT_W-1:0]     free_head = '0;
  logic [ffsa_pkg::SLOT_W-1:0]     free_tail = '0;
  logic [ffsa_pkg::LIVE_W-1:0]     free_fill = '0;
  logic [ffsa_pkg::LIVE_W-1:0]     live_cnt = '0;
  logic [ffsa_pkg::POOL_DEPTH-1:0] in_use = '0;

  ffsa_pkg::result_t pending_results [$];
  int unsigned       error_count = 0;
  int unsigned       cycle_count = 0;
  int unsigned       random_sent = 0;
  bit                idling_on = 1'b1;
  int unsigned       pop_stall = 0;

  fifo_free_list_slot_allocator_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .push           (push),
    .full           (full),
    .operation_i    (operation_i),
    .release_slot_i (release_slot_i),
    .empty          (empty),
    .pop            (pop),
    .status_o       (status_o),
    .granted_slot_o (granted_slot_o),
    .live_count_o   (live_count_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic ffsa_pkg::result_t serve_request(logic op,
                                                      logic [ffsa_pkg::SLOT_W-1:0] slot);
    ffsa_pkg::result_t          res;
    logic [ffsa_pkg::CAP_W-1:0] eff_cap;
    eff_cap = (capacity_q > ffsa_pkg::CAP_W'(ffsa_pkg::POOL_DEPTH)) ?
              ffsa_pkg::CAP_W'(ffsa_pkg::POOL_DEPTH) : capacity_q;
    res.status = ffsa_pkg::ST_OK;
    res.granted_slot = '0;
    if (op == ffsa_pkg::OP_ALLOC) begin
      if (live_cnt >= eff_cap) begin
        res.status = ffsa_pkg::ST_FULL;
      end else begin
        // reuse the oldest freed slot, else hand out the next fresh one
        if (free_fill != '0) begin
          res.granted_slot = free_ring[free_head];
          free_head = free_head + ffsa_pkg::SLOT_W'(1);
          free_fill = free_fill - ffsa_pkg::LIVE_W'(1);
        end else begin
          res.granted_slot = live_cnt[ffsa_pkg::SLOT_W-1:0];
        end
        in_use[res.granted_slot] = 1'b1;
        live_cnt = live_cnt + ffsa_pkg::LIVE_W'(1);
      end
    end else begin
      if (ffsa_pkg::CAP_W'(slot) >= eff_cap) begin
        res.status = ffsa_pkg::ST_RANGE;
      end else if (!in_use[slot]) begin
        res.status = ffsa_pkg::ST_NOT_LIVE;
      end else begin
        in_use[slot] = 1'b0;
        if (free_fill < ffsa_pkg::LIVE_W'(ffsa_pkg::POOL_DEPTH)) begin
          free_ring[free_tail] = slot;
          free_tail = free_tail + ffsa_pkg::SLOT_W'(1);
          free_fill = free_fill + ffsa_pkg::LIVE_W'(1);
        end
        if (live_cnt != '0) live_cnt = live_cnt - ffsa_pkg::LIVE_W'(1);
      end
    end
    res.live_count = live_cnt;
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    if (error_count < PRINT_LIMIT) $display("[%0t] MISMATCH: %s", $realtime, what);
    error_count++;
  endtask

  // called at a falling edge; returns at the falling edge after the word is taken
  task automatic send_request(input logic op, input logic [ffsa_pkg::SLOT_W-1:0] slot,
                              input logic typed, input ffsa_pkg::status_e st,
                              input logic [ffsa_pkg::SLOT_W-1:0] gslot,
                              input logic [ffsa_pkg::LIVE_W-1:0] live);
    ffsa_pkg::result_t predicted;
    if (idling_on && $urandom_range(0, 7) == 0) begin
      push = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    push = 1'b1;
    operation_i = op;
    release_slot_i = slot;
    do @(posedge clk_i); while (full);
    predicted = serve_request(op, slot);
    if (typed) begin
      predicted.status = st;
      predicted.granted_slot = gslot;
      predicted.live_count = live;
    end
    pending_results = {pending_results, predicted};
    @(negedge clk_i);
  endtask

  // hold off until every word is back and the pipe is quiet, then write
  task automatic write_capacity(input logic [ffsa_pkg::CAP_W-1:0] value);
    push = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    capacity_q = value;
  endtask

  function automatic logic [ffsa_pkg::SLOT_W-1:0] pick_release_slot();
    logic [ffsa_pkg::SLOT_W-1:0] live_list [$];
    for (int s = 0; s < ffsa_pkg::POOL_DEPTH; s++) begin
      if (in_use[s]) live_list = {live_list, ffsa_pkg::SLOT_W'(s)};
    end
    if (live_list.size() != 0 && $urandom_range(0, 4) != 0) begin
      return live_list[$urandom_range(0, live_list.size() - 1)];
    end
    return ffsa_pkg::SLOT_W'($urandom_range(0, ffsa_pkg::POOL_DEPTH - 1));
  endfunction

  function automatic logic [ffsa_pkg::CAP_W-1:0] pick_capacity();
    case ($urandom_range(0, 6))
      0: return ffsa_pkg::CAP_W'(0);
      1: return ffsa_pkg::CAP_W'(1);
      2, 3: return ffsa_pkg::CAP_W'(ffsa_pkg::POOL_DEPTH);
      4: return ffsa_pkg::CAP_W'(127);
      5: return ffsa_pkg::CAP_W'($urandom_range(2, 8));
      default: return ffsa_pkg::CAP_W'($urandom_range(1, 127));
    endcase
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: status %0d slot %0d live %0d",
                                  status_o, granted_slot_o, live_count_o));
      end else begin
        if (status_o != pending_results[0].status)
          report_mismatch($sformatf("status %0d, want %0d", status_o,
                                    pending_results[0].status));
        if (granted_slot_o != pending_results[0].granted_slot)
          report_mismatch($sformatf("granted_slot %0d, want %0d", granted_slot_o,
                                    pending_results[0].granted_slot));
        if (live_count_o != pending_results[0].live_count)
          report_mismatch($sformatf("live_count %0d, want %0d", live_count_o,
                                    pending_results[0].live_count));
        void'(pending_results.pop_front());
      end
    end
  end

  // result side: stall in short bursts while idling is on
  initial begin
    forever begin
      @(negedge clk_i);
      if (pop_stall != 0) begin
        pop = 1'b0;
        pop_stall--;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
        pop = 1'b0;
        pop_stall = $urandom_range(1, 5) - 1;
      end else begin
        pop = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int unsigned run_len;
    int unsigned alloc_pct;
    logic        op;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CAPACITY) begin
        write_capacity(directed_rows[i].arg);
      end else begin
        send_request(directed_rows[i].op, directed_rows[i].arg[ffsa_pkg::SLOT_W-1:0],
                     directed_rows[i].typed, directed_rows[i].status,
                     directed_rows[i].granted_slot, directed_rows[i].live_count);
      end
    end

    while (random_sent < RANDOM_ITEMS) begin
      // no capacity writes in the quiet tail, the drain would idle both sides
      if ((RANDOM_ITEMS - random_sent) > QUIET_TAIL && $urandom_range(0, 2) == 0)
        write_capacity(pick_capacity());
      // vary the mix so phases both fill the pool and drain it
      case ($urandom_range(0, 2))
        0: alloc_pct = 25;
        1: alloc_pct = 50;
        default: alloc_pct = 85;
      endcase
      run_len = $urandom_range(20, 90);
      for (int n = 0; n < run_len && random_sent < RANDOM_ITEMS; n++) begin
        idling_on = (RANDOM_ITEMS - random_sent) > QUIET_TAIL;
        op = ($urandom_range(1, 100) <= alloc_pct) ? ffsa_pkg::OP_ALLOC
                                                   : ffsa_pkg::OP_RELEASE;
        send_request(op, (op == ffsa_pkg::OP_RELEASE) ? pick_release_slot()
                         : ffsa_pkg::SLOT_W'($urandom_range(0, ffsa_pkg::POOL_DEPTH - 1)),
                     1'b0, ffsa_pkg::ST_OK, '0, '0);
        random_sent++;
      end
    end

    push = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
